// ----- sv/pvm_pkg.sv -----
// shared types, constants and helpers for the planar video memory map
`default_nettype none
package pvm_pkg;

  // address space and store sizes
  localparam int ADDR_W      = 20;
  localparam int PLANE_BYTES = 131072;  // power of two, 1024 .. 131072
  localparam int PLANES      = 4;       // 1 .. 4
  localparam int RAM_TOP     = 786432;  // even, 16384 .. 786432

  localparam logic [ADDR_W-1:0] VID_LO = 20'hc0000;
  localparam logic [ADDR_W-1:0] VID_HI = 20'he0000;

  // each store is split into an even-byte bank and an odd-byte bank
  localparam int OFF_W       = $clog2(PLANE_BYTES);
  localparam int VBANK_DEPTH = PLANE_BYTES / 2;
  localparam int VAW         = OFF_W - 1;
  localparam int MBANK_DEPTH = RAM_TOP / 2;
  localparam int MAW         = $clog2(MBANK_DEPTH);

  // clearing pass covers the deeper of the two bank kinds
  localparam int CLR_DEPTH = (MBANK_DEPTH > VBANK_DEPTH) ? MBANK_DEPTH : VBANK_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  // bus commands
  localparam logic [1:0] CMD_READ       = 2'd0;
  localparam logic [1:0] CMD_BYTE_WRITE = 2'd1;
  localparam logic [1:0] CMD_WORD_WRITE = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BIT_SHIFT    = 3'd0,
    REG_MASK_LOW     = 3'd1,
    REG_MASK_HIGH    = 3'd2,
    REG_WRITE_PLANES = 3'd3,
    REG_READ_PLANE   = 3'd4
  } pvm_reg_e;

  // where a byte read takes its data from
  typedef enum logic [1:0] {
    SRC_MAIN  = 2'd0,
    SRC_VIDEO = 2'd1,
    SRC_ONES  = 2'd2
  } pvm_src_e;

  // controller states
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } pvm_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;    // transaction accepted, issue bank reads
    logic clear;   // clearing pass step
    logic commit;  // write back / deliver result
  } pvm_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;    // last entry of the clearing pass
    logic read_pending;  // held transaction is a byte read
    logic out_free;      // output register can take a result
  } pvm_status_t;

  function automatic logic in_video(input logic [ADDR_W-1:0] x);
    return (x >= VID_LO) && (x < VID_HI);
  endfunction

  function automatic logic in_main(input logic [ADDR_W-1:0] x);
    return x < ADDR_W'(RAM_TOP);
  endfunction

  // read plane reduced modulo the plane count
  function automatic logic [1:0] plane_mod(input logic [1:0] v);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, r} >= 3'(PLANES)) begin
        r = r - 2'(PLANES);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pvm_ram.sv -----
// generic single-write, single-read memory with registered read data
`default_nettype none
module pvm_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/pvm_ctrl.sv -----
// controller: clearing pass, accept and commit sequencing
`default_nettype none
module pvm_ctrl import pvm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  output      pvm_ctrl_t   ctrl_o,
  input  wire pvm_status_t sts_i
);

  pvm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.take = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // a read waits until the output register has room
        if (!sts_i.read_pending || sts_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // a transaction is taken only from idle and is followed by execute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.take |=> state_q == S_EXEC)
    else $error("accepted transaction did not move to execute");

  // the clearing pass ends in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && sts_i.clear_last) |=> state_q == S_IDLE)
    else $error("clearing pass did not finish into idle");

  // a read commit never overwrites a result still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.commit && sts_i.read_pending) |-> sts_i.out_free)
    else $error("read committed while output busy");

endmodule
`default_nettype wire

// ----- sv/pvm_datapath.sv -----
// datapath: decode, bus latches, plane merge, memory banks and result register
`default_nettype none
module pvm_datapath import pvm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pvm_ctrl_t          ctrl_i,
  output      pvm_status_t        sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [ADDR_W-1:0]  address_i,
  input  wire logic [15:0]        write_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         read_data_o
);

  // configuration registers
  logic [3:0] bit_shift_q;
  logic [7:0] mask_low_q, mask_high_q;
  logic [3:0] write_planes_q;
  logic [1:0] read_plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_shift_q    <= '0;
      mask_low_q     <= '0;
      mask_high_q    <= '0;
      write_planes_q <= 4'd1;
      read_plane_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIT_SHIFT:    bit_shift_q    <= cfg_wdata_i[3:0];
        REG_MASK_LOW:     mask_low_q     <= cfg_wdata_i;
        REG_MASK_HIGH:    mask_high_q    <= cfg_wdata_i;
        REG_WRITE_PLANES: write_planes_q <= cfg_wdata_i[3:0];
        REG_READ_PLANE:   read_plane_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // decode of the incoming transaction into even and odd byte lanes
  logic [ADDR_W-1:0] a1, ev_addr, od_addr;
  logic              is_rd, is_byte, is_word, is_wr, par;
  logic              has_ev, has_od, merge, plain;
  logic              ev_main_we, od_main_we, ev_p0_we, od_p0_we;
  logic [7:0]        ev_val, od_val;
  pvm_src_e          src;

  always_comb begin
    is_rd   = cmd_i == CMD_READ;
    is_byte = cmd_i == CMD_BYTE_WRITE;
    is_word = cmd_i == CMD_WORD_WRITE;
    is_wr   = is_byte | is_word;
    par     = address_i[0];
    a1      = address_i + ADDR_W'(1);
    ev_addr = par ? a1 : address_i;
    od_addr = par ? address_i : a1;
    has_ev  = is_word | (is_byte & ~par);
    has_od  = is_word | (is_byte & par);
    ev_val  = (is_word & par)  ? write_data_i[15:8] : write_data_i[7:0];
    od_val  = (is_word & ~par) ? write_data_i[15:8] : write_data_i[7:0];
    merge   = is_wr & in_video(address_i);
    plain   = is_wr & ~in_video(address_i);
    // plain bytes land in main ram or unmerged in plane 0
    ev_main_we = plain & has_ev & in_main(ev_addr);
    od_main_we = plain & has_od & in_main(od_addr);
    ev_p0_we   = plain & has_ev & in_video(ev_addr);
    od_p0_we   = plain & has_od & in_video(od_addr);
    if (in_video(address_i)) begin
      src = SRC_VIDEO;
    end else if (in_main(address_i)) begin
      src = SRC_MAIN;
    end else begin
      src = SRC_ONES;
    end
  end

  // held transaction
  logic              rd_q, merge_q, has_ev_q, has_od_q;
  logic              ev_main_we_q, od_main_we_q, ev_p0_we_q, od_p0_we_q;
  logic [7:0]        ev_val_q, od_val_q;
  logic [ADDR_W-1:0] ev_addr_q, od_addr_q;
  logic              par_q;
  pvm_src_e          src_q;
  logic [7:0]        low_latch_q, high_latch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q         <= 1'b0;
      merge_q      <= 1'b0;
      has_ev_q     <= 1'b0;
      has_od_q     <= 1'b0;
      ev_main_we_q <= 1'b0;
      od_main_we_q <= 1'b0;
      ev_p0_we_q   <= 1'b0;
      od_p0_we_q   <= 1'b0;
      src_q        <= SRC_ONES;
      low_latch_q  <= '0;
      high_latch_q <= '0;
    end else if (ctrl_i.take) begin
      rd_q         <= is_rd;
      merge_q      <= merge;
      has_ev_q     <= has_ev;
      has_od_q     <= has_od;
      ev_main_we_q <= ev_main_we;
      od_main_we_q <= od_main_we;
      ev_p0_we_q   <= ev_p0_we;
      od_p0_we_q   <= od_p0_we;
      src_q        <= src;
      // every write latches its bus bytes
      if (is_wr && has_ev) begin
        low_latch_q <= ev_val;
      end
      if (is_wr && has_od) begin
        high_latch_q <= od_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      ev_val_q  <= ev_val;
      od_val_q  <= od_val;
      ev_addr_q <= ev_addr;
      od_addr_q <= od_addr;
      par_q     <= par;
    end
  end

  // replicated bus word shifted right
  logic [31:0] bus_w;
  logic [7:0]  new_lo, new_hi;

  always_comb begin
    bus_w  = {high_latch_q, low_latch_q, high_latch_q, low_latch_q} >> bit_shift_q;
    new_lo = bus_w[7:0];
    new_hi = bus_w[15:8];
  end

  // clearing pass counter
  logic [CLR_W-1:0] clr_q;
  logic             clr_main_en, clr_vid_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clear) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  assign clr_main_en = ctrl_i.clear && ({1'b0, clr_q} < (CLR_W+1)'(MBANK_DEPTH));
  assign clr_vid_en  = ctrl_i.clear && ({1'b0, clr_q} < (CLR_W+1)'(VBANK_DEPTH));

  // main ram banks
  logic           main_ev_we, main_od_we;
  logic [MAW-1:0] main_ev_wa, main_od_wa;
  logic [7:0]     main_ev_wd, main_od_wd, main_ev_rd, main_od_rd;

  always_comb begin
    if (ctrl_i.clear) begin
      main_ev_we = clr_main_en;
      main_od_we = clr_main_en;
      main_ev_wa = clr_q[MAW-1:0];
      main_od_wa = clr_q[MAW-1:0];
      main_ev_wd = '0;
      main_od_wd = '0;
    end else begin
      main_ev_we = ctrl_i.commit & ev_main_we_q;
      main_od_we = ctrl_i.commit & od_main_we_q;
      main_ev_wa = ev_addr_q[MAW:1];
      main_od_wa = od_addr_q[MAW:1];
      main_ev_wd = ev_val_q;
      main_od_wd = od_val_q;
    end
  end

  pvm_ram #(.Depth(MBANK_DEPTH), .Width(8)) u_main_ev (
    .clk_i   (clk_i),
    .we_i    (main_ev_we),
    .waddr_i (main_ev_wa),
    .wdata_i (main_ev_wd),
    .re_i    (ctrl_i.take),
    .raddr_i (ev_addr[MAW:1]),
    .rdata_o (main_ev_rd)
  );

  pvm_ram #(.Depth(MBANK_DEPTH), .Width(8)) u_main_od (
    .clk_i   (clk_i),
    .we_i    (main_od_we),
    .waddr_i (main_od_wa),
    .wdata_i (main_od_wd),
    .re_i    (ctrl_i.take),
    .raddr_i (od_addr[MAW:1]),
    .rdata_o (main_od_rd)
  );

  // video plane banks with read-modify-write merge
  logic [7:0] vid_ev_rd [PLANES];
  logic [7:0] vid_od_rd [PLANES];

  for (genvar pl = 0; pl < PLANES; pl++) begin : g_plane
    localparam bit IsPlane0 = (pl == 0);
    logic           ev_we, od_we;
    logic [VAW-1:0] ev_wa, od_wa;
    logic [7:0]     ev_wd, od_wd;

    always_comb begin
      if (ctrl_i.clear) begin
        ev_we = clr_vid_en;
        od_we = clr_vid_en;
        ev_wa = clr_q[VAW-1:0];
        od_wa = clr_q[VAW-1:0];
        ev_wd = '0;
        od_wd = '0;
      end else begin
        ev_we = ctrl_i.commit & ((merge_q & has_ev_q & write_planes_q[pl])
                                 | (IsPlane0 & ev_p0_we_q));
        od_we = ctrl_i.commit & ((merge_q & has_od_q & write_planes_q[pl])
                                 | (IsPlane0 & od_p0_we_q));
        ev_wa = ev_addr_q[OFF_W-1:1];
        od_wa = od_addr_q[OFF_W-1:1];
        // mask bits keep the old contents
        ev_wd = merge_q ? ((vid_ev_rd[pl] & mask_low_q) | (new_lo & ~mask_low_q))
                        : ev_val_q;
        od_wd = merge_q ? ((vid_od_rd[pl] & mask_high_q) | (new_hi & ~mask_high_q))
                        : od_val_q;
      end
    end

    pvm_ram #(.Depth(VBANK_DEPTH), .Width(8)) u_ev (
      .clk_i   (clk_i),
      .we_i    (ev_we),
      .waddr_i (ev_wa),
      .wdata_i (ev_wd),
      .re_i    (ctrl_i.take),
      .raddr_i (ev_addr[OFF_W-1:1]),
      .rdata_o (vid_ev_rd[pl])
    );

    pvm_ram #(.Depth(VBANK_DEPTH), .Width(8)) u_od (
      .clk_i   (clk_i),
      .we_i    (od_we),
      .waddr_i (od_wa),
      .wdata_i (od_wd),
      .re_i    (ctrl_i.take),
      .raddr_i (od_addr[OFF_W-1:1]),
      .rdata_o (vid_od_rd[pl])
    );
  end

  // read byte selection
  logic [1:0] rp;
  logic [7:0] vid_sel, rd_byte;

  always_comb begin
    rp      = plane_mod(read_plane_q);
    vid_sel = '0;
    for (int pl = 0; pl < PLANES; pl++) begin
      if (rp == 2'(pl)) begin
        vid_sel = par_q ? vid_od_rd[pl] : vid_ev_rd[pl];
      end
    end
    case (src_q)
      SRC_MAIN:  rd_byte = par_q ? main_od_rd : main_ev_rd;
      SRC_VIDEO: rd_byte = vid_sel;
      default:   rd_byte = 8'hff;  // gap, fill area and boot rom without image
    endcase
  end

  // result register
  logic       out_valid_q;
  logic [7:0] read_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit && rd_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && rd_q) begin
      read_data_q <= rd_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // status to controller
  assign sts_o.clear_last   = clr_q == CLR_W'(CLR_DEPTH - 1);
  assign sts_o.read_pending = rd_q;
  assign sts_o.out_free     = ~out_valid_q | ~out_stall_i;

  // accept and commit never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.take && ctrl_i.commit))
    else $error("accept and commit in the same cycle");

  // no transaction traffic during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |-> !ctrl_i.take && !ctrl_i.commit)
    else $error("transaction during clearing pass");

  // a committed read shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && rd_q) |=> out_valid_q)
    else $error("read commit lost its result");

  // a result appears only after a read commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.commit && rd_q))
    else $error("result without a read");

endmodule
`default_nettype wire

// ----- sv/planar_vram_memory_map.sv -----
// top level of the planar video memory map
`default_nettype none
// Bus memory map over a 20-bit space: main ram below RAM_TOP, four-plane video
// ram at C0000-DFFFF with shifted, masked merge writes into the enabled planes,
// and 0xFF for the gap, E0000-F7FFF and the boot rom at F8000 (no image load).
// Each transaction is accepted in idle, which issues registered reads of the
// even and odd byte banks, then the execute state merges and writes back (or
// loads the read result); a new transaction is accepted only back in idle.
// A byte read result is held in an output register; a following read waits in
// its commit cycle while that result is still stalled. After reset a clearing
// pass zeroes main and video ram over max(RAM_TOP/2, PLANE_BYTES/2) bank
// entries, 393216 with the default sizes; the input stalls meanwhile,
// configuration writes are taken at any time.
module planar_vram_memory_map import pvm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [15:0]       write_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [7:0]        read_data_o
);

  pvm_ctrl_t   ctrl;
  pvm_status_t sts;

  // sequencing
  pvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl),
    .sts_i      (sts)
  );

  // storage and merge logic
  pvm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

endmodule
`default_nettype wire
